@@ sv/frd_pkg.sv @@
// frd_pkg: shared types and codes for the fraction reducer.
// No dependencies; imported by frd_core and fraction_reducer_unit.
`timescale 1ns / 1ps

package frd_pkg;

  typedef logic status_t;

  localparam status_t STATUS_OK       = 1'b0;
  localparam status_t STATUS_ZERO_DEN = 1'b1;

endpackage

@@ sv/fraction_reducer_unit.sv @@
// fraction_reducer_unit: reduces a signed fraction to lowest terms and reports
// the gcd. Depends on frd_pkg, frd_core (which uses frd_sub).
//
//   channel | signals                                        | handshake
//   --------+------------------------------------------------+-------------------
//   in      | numerator, denominator                         | in_valid/in_ready
//   out     | reduced_numerator, reduced_denominator,        | out_valid/out_ready
//           | common_divisor, status                         |
//
// One word is loaded, then runs binary gcd steps, restores the common factors
// of two into g, performs the two exact divisions and moves into the output
// register; the gcd subtract steps and both divisions share the one
// subtractor. A zero denominator goes straight from load to done. in_ready
// is high only while the sequencer is idle; a finished word waits in the
// output register, so the next word may be taken while out_ready is low.
// rst is synchronous and clears only control state.
`timescale 1ns / 1ps

module fraction_reducer_unit #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] numerator,
  input  logic signed [DATA_WIDTH-1:0] denominator,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] reduced_numerator,
  output logic [DATA_WIDTH-2:0]        reduced_denominator,
  output logic [DATA_WIDTH-2:0]        common_divisor,
  output frd_pkg::status_t             status
);

  import frd_pkg::*;

  localparam int W = DATA_WIDTH;

  logic         start, core_idle, core_done, take;
  logic [W-1:0] mag_n, mag_d, nm, dm, g;
  status_t      core_status;
  logic         sgn;
  logic [W-1:0] rn;

  // magnitudes; the most negative value maps to 2^(W-1) exactly
  assign mag_n = numerator[W-1]   ? (W'(0) - $unsigned(numerator))   : $unsigned(numerator);
  assign mag_d = denominator[W-1] ? (W'(0) - $unsigned(denominator)) : $unsigned(denominator);

  assign in_ready = core_idle;
  assign start    = in_valid && in_ready;
  assign take     = core_done && (!out_valid || out_ready);

  frd_core #(.DATA_WIDTH(W)) u_core (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mag_n  (mag_n),
    .mag_d  (mag_d),
    .idle   (core_idle),
    .done   (core_done),
    .take   (take),
    .nm     (nm),
    .dm     (dm),
    .g      (g),
    .status (core_status)
  );

  // sign goes on the numerator; positive overflow saturates
  always_comb begin
    if (nm != '0 && sgn) begin
      rn = W'(0) - nm;
    end else if (nm[W-1]) begin
      rn = {1'b0, {(W-1){1'b1}}};
    end else begin
      rn = nm;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (start) begin
        sgn <= numerator[W-1] ^ denominator[W-1];
      end
      if (take) begin
        out_valid <= 1'b1;
        status    <= core_status;
        if (core_status == STATUS_ZERO_DEN) begin
          reduced_numerator   <= '0;
          reduced_denominator <= '0;
          common_divisor      <= '0;
        end else begin
          reduced_numerator   <= $signed(rn);
          reduced_denominator <= dm[W-1] ? {(W-1){1'b1}} : dm[W-2:0];
          common_divisor      <= g[W-1]  ? {(W-1){1'b1}} : g[W-2:0];
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ sv/frd_sub.sv @@
// frd_sub: shared subtract/compare unit for the gcd subtract and division steps.
// No dependencies.
`timescale 1ns / 1ps

module frd_sub #(
  parameter int WIDTH = 33
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  output logic [WIDTH-1:0] diff,
  output logic             borrow
);

  assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

@@ sv/frd_core.sv @@
// frd_core: sequencer for binary gcd, gcd restore shift and two restoring
// divisions; gcd and divisions share one frd_sub. Depends on frd_pkg, frd_sub.
`timescale 1ns / 1ps

module frd_core #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [DATA_WIDTH-1:0]   mag_n,
  input  logic [DATA_WIDTH-1:0]   mag_d,
  output logic                    idle,
  output logic                    done,
  input  logic                    take,
  output logic [DATA_WIDTH-1:0]   nm,
  output logic [DATA_WIDTH-1:0]   dm,
  output logic [DATA_WIDTH-1:0]   g,
  output frd_pkg::status_t        status
);

  import frd_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int CW = $clog2(W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_GCD,
    S_SHIFT,
    S_DIVN,
    S_DIVD,
    S_DONE
  } state_t;

  state_t       state;
  logic [W-1:0] u, v, q, r, a_hold, d_hold;
  logic [CW-1:0] k, cnt;

  logic [W:0]   sub_a, sub_b, sub_diff;
  logic         sub_borrow;
  logic [W:0]   r_sh;
  logic [W-1:0] q_next, r_next;

  frd_sub #(.WIDTH(W + 1)) u_sub (
    .a      (sub_a),
    .b      (sub_b),
    .diff   (sub_diff),
    .borrow (sub_borrow)
  );

  assign r_sh = {r, q[W-1]};

  always_comb begin
    unique case (state)
      S_GCD: begin
        sub_a = {1'b0, u};
        sub_b = {1'b0, v};
      end
      default: begin
        sub_a = r_sh;
        sub_b = {1'b0, g};
      end
    endcase
  end

  // one restoring division step
  assign r_next = sub_borrow ? r_sh[W-1:0] : sub_diff[W-1:0];
  assign q_next = {q[W-2:0], ~sub_borrow};

  assign idle = (state == S_IDLE);
  assign done = (state == S_DONE);
  assign dm   = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            a_hold <= mag_n;
            d_hold <= mag_d;
            u      <= mag_n;
            v      <= mag_d;
            k      <= '0;
            if (mag_d == '0) begin
              status <= STATUS_ZERO_DEN;
              state  <= S_DONE;
            end else begin
              status <= STATUS_OK;
              state  <= S_GCD;
            end
          end
        end
        S_GCD: begin
          priority if (u == '0) begin
            g     <= v;
            state <= S_SHIFT;
          end else if (!u[0] && !v[0]) begin
            u <= u >> 1;
            v <= v >> 1;
            k <= k + 1'b1;
          end else if (!u[0]) begin
            u <= u >> 1;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (sub_borrow) begin
            // u < v: swap so the next step subtracts the small one
            u <= v;
            v <= u;
          end else begin
            u <= sub_diff[W:1];
          end
        end
        S_SHIFT: begin
          // put back the common powers of two
          if (k == '0) begin
            q     <= a_hold;
            r     <= '0;
            cnt   <= CW'(W - 1);
            state <= S_DIVN;
          end else begin
            g <= g << 1;
            k <= k - 1'b1;
          end
        end
        S_DIVN: begin
          if (cnt == '0) begin
            nm    <= q_next;
            q     <= d_hold;
            r     <= '0;
            cnt   <= CW'(W - 1);
            state <= S_DIVD;
          end else begin
            q   <= q_next;
            r   <= r_next;
            cnt <= cnt - 1'b1;
          end
        end
        S_DIVD: begin
          q <= q_next;
          r <= r_next;
          if (cnt == '0) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
